// ===== rtl/cld_pkg.sv =====
// Package for the content-length deframer: result codes, config indexes,
// header parse state and result types, and byte helper functions.
// No dependencies.
package cld_pkg;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ERROR   = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic [2:0] ERR_HDR_LONG  = 3'd0;
    localparam logic [2:0] ERR_MALFORMED = 3'd1;
    localparam logic [2:0] ERR_MISSING   = 3'd2;
    localparam logic [2:0] ERR_DUPLICATE = 3'd3;
    localparam logic [2:0] ERR_BAD_VALUE = 3'd4;
    localparam logic [2:0] ERR_OVERSIZE  = 3'd5;
    localparam logic [2:0] ERR_TRUNCATED = 3'd6;

    localparam logic CFG_MAX_PAYLOAD = 1'b0;
    localparam logic CFG_MAX_HEADER  = 1'b1;

    localparam logic [31:0] MAX_PAYLOAD_RST = 32'd16777216;
    localparam logic [15:0] MAX_HEADER_RST  = 16'd4096;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;

    localparam logic [4:0] CL_NAME_SIZE = 5'd14;
    localparam logic [7:0] CL_NAME [0:13] = '{
        8'h63, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74,
        8'h2D, 8'h6C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68
    };

    localparam logic [32:0] ACC_CAP = 33'h1_0000_0000;

    typedef struct packed {
        logic [15:0] header_count;
        logic        pending_cr;
        logic        line_has_bytes;
        logic [4:0]  name_index;
        logic        name_mismatch;
        logic        colon_seen;
        logic [1:0]  value_phase;
        logic [32:0] value_acc;
        logic        length_seen;
        logic        err_valid;
        logic [2:0]  err_code;
    } t_hdr;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload_byte;
        logic       last;
        logic [2:0] error_code;
    } t_res;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

// ===== rtl/cld_if.sv =====
// Request and result channel interfaces of the content-length deframer.
// Depends on nothing beyond plain logic types.
interface cld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

interface cld_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       last;
    logic [2:0] error_code;

    modport source (output valid, output kind, output payload_byte, output last,
                    output error_code, input ready);
    modport sink (input valid, input kind, input payload_byte, input last,
                  input error_code, output ready);
endinterface

// ===== rtl/cld_parse.sv =====
// Header parser and payload counter: frame state registers and the per-byte
// next-state logic. Produces at most one result per accepted request.
// Depends on cld_pkg.
module cld_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [7:0]          i_data,
    input  logic                i_end,
    input  logic [31:0]         i_max_payload,
    input  logic [15:0]         i_max_header,
    output cld_pkg::t_res       o_res,
    output logic                o_res_valid
);

    localparam logic [1:0] VP_LEAD  = 2'd0;
    localparam logic [1:0] VP_DIGIT = 2'd1;
    localparam logic [1:0] VP_TRAIL = 2'd2;
    localparam logic [1:0] VP_SKIP  = 2'd3;

    cld_pkg::t_hdr r_hdr, n_hdr;
    logic          r_phase, n_phase;
    logic [31:0]   r_rem, n_rem;

    function automatic cld_pkg::t_hdr line_clear(input cld_pkg::t_hdr s);
        cld_pkg::t_hdr r;
        r = s;
        r.line_has_bytes = 1'b0;
        r.name_index     = '0;
        r.name_mismatch  = 1'b0;
        r.colon_seen     = 1'b0;
        r.value_phase    = VP_LEAD;
        r.value_acc      = '0;
        return r;
    endfunction

    function automatic cld_pkg::t_hdr hdr_clear();
        cld_pkg::t_hdr r;
        r = '0;
        return r;
    endfunction

    function automatic cld_pkg::t_hdr line_byte(input cld_pkg::t_hdr s, input logic [7:0] c);
        cld_pkg::t_hdr r;
        logic [36:0]   acc;
        r = s;
        acc = ({4'd0, s.value_acc} << 3) + ({4'd0, s.value_acc} << 1)
            + {33'd0, c[3:0]};
        r.line_has_bytes = 1'b1;
        if (!s.err_valid) begin
            if (!s.colon_seen) begin
                if (c == cld_pkg::CH_COLON) begin
                    r.colon_seen = 1'b1;
                    if (s.name_index == '0) begin
                        r.err_valid = 1'b1;
                        r.err_code  = cld_pkg::ERR_MALFORMED;
                    end else if (!s.name_mismatch && s.name_index == cld_pkg::CL_NAME_SIZE) begin
                        if (s.length_seen) begin
                            r.err_valid = 1'b1;
                            r.err_code  = cld_pkg::ERR_DUPLICATE;
                        end
                        r.value_phase = VP_LEAD;
                    end else begin
                        r.value_phase = VP_SKIP;
                    end
                end else begin
                    if (s.name_index >= cld_pkg::CL_NAME_SIZE) begin
                        r.name_mismatch = 1'b1;
                    end else if (cld_pkg::to_lower(c) != cld_pkg::CL_NAME[s.name_index[3:0]]) begin
                        r.name_mismatch = 1'b1;
                    end
                    if (s.name_index != 5'd31) begin
                        r.name_index = s.name_index + 5'd1;
                    end
                end
            end else begin
                unique case (s.value_phase)
                    VP_LEAD: begin
                        if (cld_pkg::is_digit(c)) begin
                            r.value_acc   = {29'd0, c[3:0]};
                            r.value_phase = VP_DIGIT;
                        end else if (!cld_pkg::is_blank(c)) begin
                            r.err_valid = 1'b1;
                            r.err_code  = cld_pkg::ERR_BAD_VALUE;
                        end
                    end
                    VP_DIGIT: begin
                        if (cld_pkg::is_digit(c)) begin
                            if (acc > {4'd0, cld_pkg::ACC_CAP}) begin
                                r.value_acc = cld_pkg::ACC_CAP;
                            end else begin
                                r.value_acc = acc[32:0];
                            end
                        end else if (cld_pkg::is_blank(c)) begin
                            r.value_phase = VP_TRAIL;
                        end else begin
                            r.err_valid = 1'b1;
                            r.err_code  = cld_pkg::ERR_BAD_VALUE;
                        end
                    end
                    VP_TRAIL: begin
                        if (!cld_pkg::is_blank(c)) begin
                            r.err_valid = 1'b1;
                            r.err_code  = cld_pkg::ERR_BAD_VALUE;
                        end
                    end
                    VP_SKIP: begin
                    end
                endcase
            end
        end
        return r;
    endfunction

    always_comb begin
        cld_pkg::t_hdr h;
        logic          closed;
        h           = r_hdr;
        closed      = 1'b0;
        n_hdr       = r_hdr;
        n_phase     = r_phase;
        n_rem       = r_rem;
        o_res       = '0;
        o_res_valid = 1'b0;
        if (i_end) begin
            o_res_valid = 1'b1;
            if (r_phase || r_hdr.header_count != '0) begin
                o_res.kind       = cld_pkg::KIND_ERROR;
                o_res.error_code = cld_pkg::ERR_TRUNCATED;
            end else begin
                o_res.kind = cld_pkg::KIND_END;
            end
            n_phase = 1'b0;
            n_rem   = '0;
            n_hdr   = hdr_clear();
        end else if (r_phase) begin
            o_res_valid        = 1'b1;
            o_res.kind         = cld_pkg::KIND_PAYLOAD;
            o_res.payload_byte = i_data;
            if (r_rem <= 32'd1) begin
                o_res.last = 1'b1;
                n_rem      = '0;
                n_phase    = 1'b0;
            end else begin
                n_rem = r_rem - 32'd1;
            end
        end else begin
            if (h.header_count != 16'hFFFF) begin
                h.header_count = h.header_count + 16'd1;
            end
            if (h.pending_cr) begin
                h.pending_cr = 1'b0;
                if (i_data == cld_pkg::CH_LF) begin
                    if (!h.line_has_bytes) begin
                        if (h.header_count == 16'd2) begin
                            if (!h.err_valid) begin
                                h.err_valid = 1'b1;
                                h.err_code  = cld_pkg::ERR_MALFORMED;
                            end
                            h = line_clear(h);
                        end else begin
                            closed = 1'b1;
                        end
                    end else begin
                        if (!h.err_valid) begin
                            if (!h.colon_seen) begin
                                h.err_valid = 1'b1;
                                h.err_code  = cld_pkg::ERR_MALFORMED;
                            end else if (h.value_phase != VP_SKIP) begin
                                if (h.value_phase == VP_LEAD) begin
                                    h.err_valid = 1'b1;
                                    h.err_code  = cld_pkg::ERR_BAD_VALUE;
                                end else if (h.value_acc > {1'b0, i_max_payload}) begin
                                    h.err_valid = 1'b1;
                                    h.err_code  = cld_pkg::ERR_OVERSIZE;
                                end else begin
                                    h.length_seen = 1'b1;
                                    n_rem         = h.value_acc[31:0];
                                end
                            end
                        end
                        h = line_clear(h);
                    end
                end else begin
                    h = line_byte(h, cld_pkg::CH_CR);
                    if (i_data == cld_pkg::CH_CR) begin
                        h.pending_cr = 1'b1;
                    end else begin
                        h = line_byte(h, i_data);
                    end
                end
            end else if (i_data == cld_pkg::CH_CR) begin
                h.pending_cr = 1'b1;
            end else begin
                h = line_byte(h, i_data);
            end

            if (closed) begin
                if (h.err_valid) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = cld_pkg::KIND_ERROR;
                    o_res.error_code = h.err_code;
                    n_rem            = '0;
                end else if (!h.length_seen) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = cld_pkg::KIND_ERROR;
                    o_res.error_code = cld_pkg::ERR_MISSING;
                    n_rem            = '0;
                end else if (n_rem == '0) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = cld_pkg::KIND_EMPTY;
                end else begin
                    n_phase = 1'b1;
                end
                n_hdr = hdr_clear();
            end else if (h.header_count >= i_max_header) begin
                o_res_valid      = 1'b1;
                o_res.kind       = cld_pkg::KIND_ERROR;
                o_res.error_code = cld_pkg::ERR_HDR_LONG;
                n_rem            = '0;
                n_hdr            = hdr_clear();
            end else begin
                n_hdr = h;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr   <= hdr_clear();
            r_phase <= 1'b0;
            r_rem   <= '0;
        end else if (i_fire) begin
            r_hdr   <= n_hdr;
            r_phase <= n_phase;
            r_rem   <= n_rem;
        end
    end

endmodule

// ===== rtl/cld_outreg.sv =====
// Result register of the deframer: holds one result until the receiver
// takes it and tells the request side when a new request may enter.
// Depends on cld_pkg.
module cld_outreg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic          i_res_valid,
    input  cld_pkg::t_res i_res,
    input  logic          i_ready,
    output logic          o_valid,
    output cld_pkg::t_res o_res,
    output logic          o_can_take
);

    logic          r_valid;
    cld_pkg::t_res r_res;

    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_fire) begin
            r_valid <= i_res_valid;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== rtl/content_length_deframer_core.sv =====
// Content-length deframer top level: request and result channels,
// configuration registers, parser and result register.
// Depends on cld_pkg, cld_if, cld_parse and cld_outreg.
//
// Usage: i_req carries one stream byte per request, or stream_end to mark
// the close of the stream. Each request gives zero or one result on o_res:
// a payload byte (last set on the final one), an empty frame, an error with
// its code, or a clean end of stream. Header bytes give no result unless they
// close an empty or faulty header block, or reach the header byte limit.
// A result is registered and appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless the receiver stalls; the whole
// parse step for a byte lies between the frame state and result registers.
// When the receiver stalls, the result is held and i_req.ready drops only
// while a held result is not being taken, so at most one result waits.
// Reset clears the frame state, the result register and loads the limits
// with 16777216 payload bytes and 4096 header bytes. Write the limits
// through i_cfg_we / i_cfg_idx / i_cfg_data only while the block is idle.
module content_length_deframer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cld_in_if.sink      i_req,
    cld_out_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    logic [31:0]   r_max_payload;
    logic [15:0]   r_max_header;
    logic          fire;
    logic          can_take;
    logic          step_valid;
    cld_pkg::t_res step_res;
    cld_pkg::t_res out_res;

    assign i_req.ready = can_take;
    assign fire        = i_req.valid && can_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= cld_pkg::MAX_PAYLOAD_RST;
            r_max_header  <= cld_pkg::MAX_HEADER_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cld_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                cld_pkg::CFG_MAX_HEADER:  r_max_header  <= i_cfg_data[15:0];
            endcase
        end
    end

    cld_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_data        (i_req.data_byte),
        .i_end         (i_req.stream_end),
        .i_max_payload (r_max_payload),
        .i_max_header  (r_max_header),
        .o_res         (step_res),
        .o_res_valid   (step_valid)
    );

    cld_outreg u_outreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_res_valid (step_valid),
        .i_res       (step_res),
        .i_ready     (o_res.ready),
        .o_valid     (o_res.valid),
        .o_res       (out_res),
        .o_can_take  (can_take)
    );

    assign o_res.kind         = out_res.kind;
    assign o_res.payload_byte = out_res.payload_byte;
    assign o_res.last         = out_res.last;
    assign o_res.error_code   = out_res.error_code;

endmodule

// ===== rtl/cld_checker.sv =====
// Port-level checks for the content-length deframer, bound to the top level.
// Depends on cld_pkg and content_length_deframer_core.
module cld_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_kind,
    input logic [7:0] i_payload_byte,
    input logic       i_last,
    input logic [2:0] i_error_code
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_kind)
            && $stable(i_payload_byte) && $stable(i_last) && $stable(i_error_code))
        else $error("result changed while stalled");

    a_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid || i_out_ready |-> i_in_ready)
        else $error("request side blocked with free result register");

    a_nonpayload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != cld_pkg::KIND_PAYLOAD |-> i_payload_byte == 8'd0 && !i_last)
        else $error("payload fields set on a non-payload result");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == cld_pkg::KIND_ERROR) ?
            (i_error_code <= cld_pkg::ERR_TRUNCATED) : (i_error_code == 3'd0))
        else $error("error code inconsistent with result kind");

endmodule

bind content_length_deframer_core cld_checker u_cld_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_req.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_kind         (o_res.kind),
    .i_payload_byte (o_res.payload_byte),
    .i_last         (o_res.last),
    .i_error_code   (o_res.error_code)
);

// ===== bench/tb_content_length_deframer_core.sv =====
// Testbench for content_length_deframer_core: directed header blocks, then random
// well-formed, broken and noisy streams under several limits, checked per result.
// Depends on cld_pkg, the cld_in_if / cld_out_if interfaces and the core itself.
module tb_content_length_deframer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          QUIET_LIMIT = 5000;
    localparam int          NAME_CHARS  = 14;
    localparam logic [32:0] ACC_TOP     = 33'h1_0000_0000;
    localparam logic [8*NAME_CHARS-1:0] LEN_NAME = "content-length";

    typedef enum logic [1:0] {VAL_LEAD, VAL_DIGITS, VAL_TRAIL, VAL_SKIP} t_val_state;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } t_item;

    typedef struct {
        string      txt;
        logic       fin;
        logic       typed;
        logic [1:0] kind;
        logic [2:0] code;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    cld_in_if  req_if();
    cld_out_if res_if();

    content_length_deframer_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    logic [31:0] lim_pay;
    logic [15:0] lim_hdr;
    logic        in_payload;
    logic [31:0] remain;
    logic [15:0] hcnt;
    logic        cr_wait;
    logic        line_any;
    logic [4:0]  nidx;
    logic        nbad;
    logic        got_colon;
    t_val_state  vstate;
    logic [32:0] vacc;
    logic        have_len;
    logic        hold_err;
    logic [2:0]  hold_code;

    cld_pkg::t_res owed_results [$];
    t_item         frag [$];
    logic          drv_typed;
    cld_pkg::t_res drv_tres;
    bit            idle_en;
    int            bad_results;
    int            quiet_cycles;
    int            items_sent;

    t_row dir_rows [18] = '{
        '{"", 1'b1, 1'b1, cld_pkg::KIND_END, 3'd0},
        '{"Content-Length: 0\015\012\015\012", 1'b0, 1'b1, cld_pkg::KIND_EMPTY, 3'd0},
        '{"content-length:3\015\012\015\012a\377c", 1'b0, 1'b0,
          cld_pkg::KIND_PAYLOAD, 3'd0},
        '{"X-A: b\015\012CONTENT-LENGTH: \t 2 \t\015\012\015\012hi",
          1'b0, 1'b0, cld_pkg::KIND_PAYLOAD, 3'd0},
        '{"\015\012Content-Length: 1\015\012\015\012", 1'b0, 1'b1,
          cld_pkg::KIND_ERROR, cld_pkg::ERR_MALFORMED},
        '{": x\015\012\015\012", 1'b0, 1'b1, cld_pkg::KIND_ERROR, cld_pkg::ERR_MALFORMED},
        '{"noColon\015\012\015\012", 1'b0, 1'b1,
          cld_pkg::KIND_ERROR, cld_pkg::ERR_MALFORMED},
        '{"Other: 5\015\012\015\012", 1'b0, 1'b1, cld_pkg::KIND_ERROR, cld_pkg::ERR_MISSING},
        '{"Content-Length: 1\015\012content-length: 1\015\012\015\012",
          1'b0, 1'b1, cld_pkg::KIND_ERROR, cld_pkg::ERR_DUPLICATE},
        '{"Content-Length:\015\012\015\012", 1'b0, 1'b1,
          cld_pkg::KIND_ERROR, cld_pkg::ERR_BAD_VALUE},
        '{"Content-Length: 1x\015\012\015\012", 1'b0, 1'b1,
          cld_pkg::KIND_ERROR, cld_pkg::ERR_BAD_VALUE},
        '{"Content-Length: 99999999999999999999\015\012\015\012",
          1'b0, 1'b1, cld_pkg::KIND_ERROR, cld_pkg::ERR_OVERSIZE},
        '{"Content-Length: 16777217\015\012\015\012", 1'b0, 1'b1,
          cld_pkg::KIND_ERROR, cld_pkg::ERR_OVERSIZE},
        '{"Content-Length: 2\015\012\015\012a", 1'b1, 1'b1,
          cld_pkg::KIND_ERROR, cld_pkg::ERR_TRUNCATED},
        '{"Conte", 1'b1, 1'b1, cld_pkg::KIND_ERROR, cld_pkg::ERR_TRUNCATED},
        '{"A\015\015: q\015\012Content-Length: 1\015\012\015\012Z",
          1'b0, 1'b0, cld_pkg::KIND_PAYLOAD, 3'd0},
        '{"Content-Length: 2 3\015\012\015\012", 1'b0, 1'b1,
          cld_pkg::KIND_ERROR, cld_pkg::ERR_BAD_VALUE},
        '{"Content-Lengthx: 4\015\012\015\012", 1'b0, 1'b1,
          cld_pkg::KIND_ERROR, cld_pkg::ERR_MISSING}
    };

    function automatic void clr_line();
        line_any  = 1'b0;
        nidx      = '0;
        nbad      = 1'b0;
        got_colon = 1'b0;
        vstate    = VAL_LEAD;
        vacc      = '0;
    endfunction

    function automatic void clr_hdr();
        clr_line();
        hcnt      = '0;
        cr_wait   = 1'b0;
        have_len  = 1'b0;
        hold_err  = 1'b0;
        hold_code = cld_pkg::ERR_HDR_LONG;
    endfunction

    function automatic void reset_deframer();
        lim_pay    = cld_pkg::MAX_PAYLOAD_RST;
        lim_hdr    = cld_pkg::MAX_HEADER_RST;
        in_payload = 1'b0;
        remain     = '0;
        clr_hdr();
    endfunction

    function automatic void flag(input logic [2:0] code);
        if (!hold_err) begin
            hold_err  = 1'b1;
            hold_code = code;
        end
    endfunction

    function automatic void take_line_byte(input logic [7:0] c);
        logic        dig;
        logic        blank;
        logic [7:0]  low;
        logic [36:0] grown;
        dig   = (c >= 8'h30) && (c <= 8'h39);
        blank = (c == 8'h20) || (c == 8'h09);
        low   = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
        line_any = 1'b1;
        if (hold_err) return;
        if (!got_colon) begin
            if (c == cld_pkg::CH_COLON) begin
                got_colon = 1'b1;
                if (nidx == 0) begin
                    flag(cld_pkg::ERR_MALFORMED);
                end else if (!nbad && nidx == NAME_CHARS) begin
                    if (have_len) flag(cld_pkg::ERR_DUPLICATE);
                    vstate = VAL_LEAD;
                end else begin
                    vstate = VAL_SKIP;
                end
            end else begin
                if (nidx >= NAME_CHARS || low != LEN_NAME[8*(NAME_CHARS-1-nidx) +: 8]) begin
                    nbad = 1'b1;
                end
                if (nidx != 5'd31) nidx++;
            end
            return;
        end
        case (vstate)
            VAL_LEAD: begin
                if (dig) begin
                    vacc   = 33'(c - 8'h30);
                    vstate = VAL_DIGITS;
                end else if (!blank) begin
                    flag(cld_pkg::ERR_BAD_VALUE);
                end
            end
            VAL_DIGITS: begin
                if (dig) begin
                    grown = {4'b0, vacc} * 37'd10 + 37'(c - 8'h30);
                    vacc  = (grown > 37'(ACC_TOP)) ? ACC_TOP : grown[32:0];
                end else if (blank) begin
                    vstate = VAL_TRAIL;
                end else begin
                    flag(cld_pkg::ERR_BAD_VALUE);
                end
            end
            VAL_TRAIL: begin
                if (!blank) flag(cld_pkg::ERR_BAD_VALUE);
            end
            default: ;
        endcase
    endfunction

    function automatic logic close_line();
        if (!line_any) begin
            if (hcnt == 16'd2) begin
                flag(cld_pkg::ERR_MALFORMED);
                clr_line();
                return 1'b0;
            end
            return 1'b1;
        end
        if (!hold_err) begin
            if (!got_colon) begin
                flag(cld_pkg::ERR_MALFORMED);
            end else if (vstate != VAL_SKIP) begin
                if (vstate == VAL_LEAD) begin
                    flag(cld_pkg::ERR_BAD_VALUE);
                end else if (vacc > {1'b0, lim_pay}) begin
                    flag(cld_pkg::ERR_OVERSIZE);
                end else begin
                    have_len = 1'b1;
                    remain   = vacc[31:0];
                end
            end
        end
        clr_line();
        return 1'b0;
    endfunction

    function automatic logic deframe_byte(input logic [7:0] c, input logic fin,
                                          output cld_pkg::t_res r);
        logic closed;
        r      = '0;
        closed = 1'b0;
        if (fin) begin
            if (in_payload || hcnt != 0) begin
                r.kind       = cld_pkg::KIND_ERROR;
                r.error_code = cld_pkg::ERR_TRUNCATED;
            end else begin
                r.kind = cld_pkg::KIND_END;
            end
            in_payload = 1'b0;
            remain     = '0;
            clr_hdr();
            return 1'b1;
        end
        if (in_payload) begin
            r.kind         = cld_pkg::KIND_PAYLOAD;
            r.payload_byte = c;
            if (remain <= 1) begin
                r.last     = 1'b1;
                remain     = '0;
                in_payload = 1'b0;
            end else begin
                remain--;
            end
            return 1'b1;
        end
        if (hcnt != 16'hFFFF) hcnt++;
        if (cr_wait) begin
            cr_wait = 1'b0;
            if (c == cld_pkg::CH_LF) begin
                closed = close_line();
            end else begin
                take_line_byte(cld_pkg::CH_CR);
                if (c == cld_pkg::CH_CR) cr_wait = 1'b1;
                else take_line_byte(c);
            end
        end else if (c == cld_pkg::CH_CR) begin
            cr_wait = 1'b1;
        end else begin
            take_line_byte(c);
        end
        if (closed) begin
            if (hold_err) begin
                r.kind       = cld_pkg::KIND_ERROR;
                r.error_code = hold_code;
                remain       = '0;
            end else if (!have_len) begin
                r.kind       = cld_pkg::KIND_ERROR;
                r.error_code = cld_pkg::ERR_MISSING;
                remain       = '0;
            end else if (remain == 0) begin
                r.kind = cld_pkg::KIND_EMPTY;
            end else begin
                in_payload = 1'b1;
            end
            clr_hdr();
            return !in_payload;
        end
        if (hcnt >= lim_hdr) begin
            r.kind       = cld_pkg::KIND_ERROR;
            r.error_code = cld_pkg::ERR_HDR_LONG;
            remain       = '0;
            clr_hdr();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string fld, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, fld, want, got);
            bad_results++;
        end
    endfunction

    function automatic int gap_len();
        int r;
        if (!idle_en) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic void put_byte(input logic [7:0] c);
        frag.push_back('{b: c, fin: 1'b0});
    endfunction

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endfunction

    function automatic void put_fin();
        frag.push_back('{b: 8'($urandom_range(0, 255)), fin: 1'b1});
    endfunction

    function automatic void put_blanks();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < n; i++) put_byte($urandom_range(0, 1) ? 8'h20 : 8'h09);
    endfunction

    function automatic void put_len_line(input string v);
        logic [7:0] c;
        for (int i = 0; i < NAME_CHARS; i++) begin
            c = LEN_NAME[8*(NAME_CHARS-1-i) +: 8];
            if (c >= 8'h61 && $urandom_range(0, 1)) c = c - 8'h20;
            put_byte(c);
        end
        put_byte(cld_pkg::CH_COLON);
        put_blanks();
        put_str(v);
        put_blanks();
        put_byte(cld_pkg::CH_CR);
        put_byte(cld_pkg::CH_LF);
    endfunction

    function automatic void put_other_line();
        int n;
        if ($urandom_range(0, 7) == 0) begin
            put_str("Content-Type");
        end else begin
            put_str("X-");
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++) put_byte(8'($urandom_range(8'h41, 8'h5A)));
        end
        put_str(": ");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++) put_byte(8'($urandom_range(8'h30, 8'h7A)));
        put_byte(cld_pkg::CH_CR);
        put_byte(cld_pkg::CH_LF);
    endfunction

    function automatic void build_frame();
        int    r;
        int    len;
        int    n_other;
        int    pos;
        int    k;
        string v;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            k = $urandom_range(1, 30);
            for (int i = 0; i < k; i++) begin
                case ($urandom_range(0, 7))
                    0: put_byte(cld_pkg::CH_CR);
                    1: put_byte(cld_pkg::CH_LF);
                    2: put_byte(cld_pkg::CH_COLON);
                    default: put_byte(8'($urandom_range(0, 255)));
                endcase
            end
            if ($urandom_range(0, 1)) put_str("\015\012\015\012");
            return;
        end
        if (r < 12) begin
            put_fin();
            return;
        end
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(0, 12);
        v = $sformatf("%0d", len);
        if ($urandom_range(0, 5) == 0) v = {"00", v};
        r = $urandom_range(0, 99);
        if (r < 4) v = $urandom_range(0, 1) ? "4294967296" : "18446744073709551616";
        else if (r < 8) v = $urandom_range(0, 1) ? "" : {v, "x"};
        else if (r < 10) v = {v, " 7"};
        else if (r < 13) put_str("\015\012");
        n_other = $urandom_range(0, 2);
        pos = $urandom_range(0, n_other);
        for (int i = 0; i <= n_other; i++) begin
            if (i == pos && !(r >= 13 && r < 18)) put_len_line(v);
            if (i < n_other) put_other_line();
        end
        if (r >= 18 && r < 22) put_len_line(v);
        else if (r >= 22 && r < 25) put_str(": x\015\012");
        else if (r >= 25 && r < 28) put_str("nocolon\015\012");
        else if (r >= 28 && r < 31) put_str("a\015b: c\015\012");
        else if (r >= 31 && r < 36) begin
            frag[$urandom_range(0, frag.size() - 1)].b = 8'($urandom_range(0, 255));
        end
        put_str("\015\012");
        if (r >= 36 && r < 42) begin
            k = (len > 0) ? $urandom_range(0, len - 1) : 0;
            for (int i = 0; i < k; i++) put_byte(8'($urandom_range(0, 255)));
            put_fin();
        end else begin
            for (int i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_item(input t_item it, input logic typed, input cld_pkg::t_res tres);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.data_byte  <= it.b;
        req_if.stream_end <= it.fin;
        drv_typed         <= typed;
        drv_tres          <= tres;
        do @(posedge i_clk);
        while (!(req_if.valid === 1'b1 && req_if.ready === 1'b1));
        items_sent++;
    endtask

    task automatic send_frag();
        foreach (frag[i]) send_item(frag[i], 1'b0, '0);
        frag.delete();
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [31:0] pay, input logic [15:0] hdr);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= cld_pkg::CFG_MAX_PAYLOAD;
        i_cfg_data <= pay;
        @(posedge i_clk);
        lim_pay = pay;
        i_cfg_idx  <= cld_pkg::CFG_MAX_HEADER;
        i_cfg_data <= {16'b0, hdr};
        @(posedge i_clk);
        lim_hdr = hdr;
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input logic [31:0] pay, input logic [15:0] hdr,
                             input bit idle, input int budget);
        int start;
        set_limits(pay, hdr);
        idle_en = idle;
        start   = items_sent;
        while (items_sent - start < budget) begin
            build_frame();
            send_frag();
        end
        drain_results();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin : rx_side
        int stall;
        stall        = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall == 0) stall = gap_len();
            res_if.ready <= (stall == 0);
            if (stall > 0) stall--;
        end
    end

    always @(posedge i_clk) begin : watch
        cld_pkg::t_res calc;
        cld_pkg::t_res want;
        logic          has;
        logic          moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
                moved = 1'b1;
                has = deframe_byte(req_if.data_byte, req_if.stream_end, calc);
                if (drv_typed) owed_results.push_back(drv_tres);
                else if (has) owed_results.push_back(calc);
            end
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                moved = 1'b1;
                if (owed_results.size() == 0) begin
                    $display("%0t: expected no result, actual kind %h byte %h last %h code %h",
                             $time, res_if.kind, res_if.payload_byte, res_if.last,
                             res_if.error_code);
                    bad_results++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("kind", 8'(want.kind), 8'(res_if.kind));
                    check_field("payload_byte", want.payload_byte, res_if.payload_byte);
                    check_field("last", 8'(want.last), 8'(res_if.last));
                    check_field("error_code", 8'(want.error_code), 8'(res_if.error_code));
                end
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("content_length_deframer_core test failed");
            $finish;
        end
    end

    initial begin : stim
        cld_pkg::t_res tres;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_idx         = cld_pkg::CFG_MAX_PAYLOAD;
        i_cfg_data        = '0;
        req_if.valid      = 1'b0;
        req_if.data_byte  = '0;
        req_if.stream_end = 1'b0;
        drv_typed         = 1'b0;
        drv_tres          = '0;
        idle_en           = 1'b1;
        bad_results       = 0;
        quiet_cycles      = 0;
        items_sent        = 0;
        reset_deframer();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            put_str(dir_rows[i].txt);
            if (dir_rows[i].fin) put_fin();
            tres = '{kind: dir_rows[i].kind, payload_byte: 8'h00, last: 1'b0,
                     error_code: dir_rows[i].code};
            foreach (frag[j]) begin
                send_item(frag[j], dir_rows[i].typed && j == frag.size() - 1, tres);
            end
            frag.delete();
        end
        drain_results();

        run_phase(32'd0, 16'd4, 1'b1, 60);
        run_phase(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 220);
        run_phase(32'd5, 16'd40, 1'b1, 220);
        run_phase(32'd100, 16'd24, 1'b1, 180);
        run_phase(cld_pkg::MAX_PAYLOAD_RST, cld_pkg::MAX_HEADER_RST, 1'b1, 220);

        if (bad_results == 0) begin
            $display("content_length_deframer_core test passed");
        end else begin
            $display("content_length_deframer_core test failed");
        end
        $finish;
    end

endmodule
